### rtl/fat12_cluster_chain_walker_core_defines.svh
// Assertion macros used by the FAT12 chain walker core.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define FAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define FAT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fat12_cw_pkg.sv
// Types and constants of the FAT12 cluster chain walker.
package fat12_cw_pkg;

  localparam int TABLE_BYTES_DEF = 8192;
  localparam int MAX_RUN_DEF     = 64;

  localparam logic [11:0] CHAIN_END          = 12'hFF8;
  localparam logic [15:0] ENTRY_MASK         = 16'h0FFF;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;
  localparam logic [19:0] SECTOR_MAX         = 20'hFFFFF;

  localparam logic [15:0] DATA_START_RESET  = 16'd0;
  localparam logic [7:0]  SPC_RESET         = 8'd1;
  localparam logic [13:0] TABLE_BYTES_RESET = 14'd6144;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WALK = 1'b1;

  localparam logic [1:0] CFG_DATA_START  = 2'd0;
  localparam logic [1:0] CFG_SPC         = 2'd1;
  localparam logic [1:0] CFG_TABLE_BYTES = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_BEYOND  = 2'd2,
    ST_CUT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_EVAL,
    S_SEND
  } state_t;

  typedef struct packed {
    logic [11:0] cluster;
    logic [19:0] sector_address;
    logic [11:0] chain_link;
    status_t     status;
    logic        last;
  } result_t;

endpackage

### rtl/fat12_cw_if.sv
// Valid/ready channel interfaces for the walker's commands and results.
interface fat12_cw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [12:0] table_offset;
  logic [7:0]  table_byte;
  logic [11:0] start_cluster;

  modport source (output valid, command, table_offset, table_byte, start_cluster,
                  input ready);
  modport sink (input valid, command, table_offset, table_byte, start_cluster,
                output ready);
endinterface

interface fat12_cw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cluster;
  logic [19:0] sector_address;
  logic [11:0] chain_link;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, cluster, sector_address, chain_link, status, last,
                  input ready);
  modport sink (input valid, cluster, sector_address, chain_link, status, last,
                output ready);
endinterface

### rtl/fat12_cluster_chain_walker_core.sv
// Top level of the FAT12 cluster chain walker: table memory and walk sequencer.
//
// Usage: in_item carries commands. A load (command 0) writes table_byte at
// table_offset into the table memory and returns one acknowledge item. A walk
// (command 1) follows the chain from start_cluster and returns one item per
// cluster, with last set on the final one. Registers are written through
// cfg_we, cfg_index and cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. A load or a bad
// start is accepted in S_IDLE and its result is sent from S_SEND. Each
// cluster of a walk passes through S_RD_LO, S_RD_HI and S_EVAL: the table
// memory has one read port, so the two bytes of an entry are read in turn,
// and the entry is decoded. A new command is taken only when the previous
// one has produced all its items. The output register holds a result while
// out_item.ready is low; the walk stalls in place until the result is
// taken. One result can wait there while the next command is accepted.
// Reset (synchronous, rst_n low) clears the control state and restores the
// register defaults; the table memory keeps no reset value and must be loaded
// before it is walked.
module fat12_cluster_chain_walker_core #(
  parameter int TABLE_BYTES = fat12_cw_pkg::TABLE_BYTES_DEF,
  parameter int MAX_RUN     = fat12_cw_pkg::MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fat12_cw_in_if.sink          in_item,
  fat12_cw_out_if.source       out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import fat12_cw_pkg::*;
  `include "fat12_cluster_chain_walker_core_defines.svh"

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int NW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rdata_r;
  logic       mem_we;
  logic [AW-1:0] mem_raddr;

  logic [15:0] data_start_r;
  logic [7:0]  spc_r;
  logic [13:0] tbytes_r;

  state_t      state_r, state_nxt;
  logic [11:0] cl_r, cl_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [19:0] prod_r, prod_nxt;
  logic        beyond_r, beyond_nxt;
  result_t     res_r, res_nxt;
  result_t     out_r, out_data;
  logic        out_valid_r, out_load, out_take;
  logic        in_fire;

  logic [12:0] pos;
  logic [13:0] pos_inc;
  logic [13:0] limit;
  logic [15:0] word;
  logic [11:0] nxt;
  logic [20:0] sec_sum;
  logic [19:0] sec;
  result_t     eval_res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_item.table_offset[AW-1:0]] <= in_item.table_byte;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r <= DATA_START_RESET;
      spc_r        <= SPC_RESET;
      tbytes_r     <= TABLE_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_START:  data_start_r <= cfg_wdata;
        CFG_SPC:         spc_r <= cfg_wdata[7:0];
        CFG_TABLE_BYTES: tbytes_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_item.valid && in_item.ready;
  assign out_take = !out_valid_r || out_item.ready;

  assign pos     = 13'(cl_r) + 13'(cl_r[11:1]);
  assign pos_inc = 14'(pos) + 14'd1;
  assign limit   = (tbytes_r < 14'(TABLE_BYTES)) ? tbytes_r : 14'(TABLE_BYTES);
  assign word    = {rdata_r, lo_r};
  assign nxt     = cl_r[0] ? word[15:4] : 12'(word & ENTRY_MASK);
  assign sec_sum = 21'(data_start_r) + 21'(prod_r);
  assign sec     = (sec_sum > 21'(SECTOR_MAX)) ? SECTOR_MAX : sec_sum[19:0];

  always_comb begin
    eval_res.cluster        = cl_r;
    eval_res.sector_address = sec;
    eval_res.chain_link     = nxt;
    eval_res.status         = ST_OK;
    eval_res.last           = 1'b0;
    if (beyond_r) begin
      eval_res.chain_link = 12'd0;
      eval_res.status     = ST_BEYOND;
      eval_res.last       = 1'b1;
    end else if (nxt >= CHAIN_END) begin
      eval_res.last = 1'b1;
    end else if (nxt < FIRST_DATA_CLUSTER) begin
      eval_res.status = ST_BAD;
      eval_res.last   = 1'b1;
    end else if (n_r == NW'(MAX_RUN - 1)) begin
      eval_res.status = ST_CUT;
      eval_res.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cl_r     <= cl_nxt;
    n_r      <= n_nxt;
    lo_r     <= lo_nxt;
    prod_r   <= prod_nxt;
    beyond_r <= beyond_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_r <= out_data;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cl_nxt     = cl_r;
    n_nxt      = n_r;
    lo_nxt     = lo_r;
    prod_nxt   = prod_r;
    beyond_nxt = beyond_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_raddr  = pos[AW-1:0];
    out_load   = 1'b0;
    out_data   = res_r;
    in_item.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          if (in_item.command == CMD_LOAD) begin
            mem_we  = 14'(in_item.table_offset) < 14'(TABLE_BYTES);
            res_nxt = '{cluster: 12'd0, sector_address: 20'd0, chain_link: 12'd0,
                        status: ST_OK, last: 1'b1};
            state_nxt = S_SEND;
          end else if (in_item.start_cluster < FIRST_DATA_CLUSTER ||
                       in_item.start_cluster >= CHAIN_END) begin
            res_nxt = '{cluster: in_item.start_cluster, sector_address: 20'd0,
                        chain_link: 12'd0, status: ST_BAD, last: 1'b1};
            state_nxt = S_SEND;
          end else begin
            cl_nxt    = in_item.start_cluster;
            n_nxt     = '0;
            state_nxt = S_RD_LO;
          end
        end
      end
      S_RD_LO: begin
        mem_raddr  = pos[AW-1:0];
        prod_nxt   = 20'(cl_r - FIRST_DATA_CLUSTER) * 20'(spc_r);
        beyond_nxt = pos_inc >= limit;
        state_nxt  = S_RD_HI;
      end
      S_RD_HI: begin
        mem_raddr = pos_inc[AW-1:0];
        lo_nxt    = rdata_r;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_take) begin
          out_load = 1'b1;
          out_data = eval_res;
          if (eval_res.last) begin
            state_nxt = S_IDLE;
          end else begin
            cl_nxt    = eval_res.chain_link;
            n_nxt     = n_r + NW'(1);
            state_nxt = S_RD_LO;
          end
        end else begin
          res_nxt   = eval_res;
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (out_take) begin
          out_load = 1'b1;
          out_data = res_r;
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            cl_nxt    = res_r.chain_link;
            n_nxt     = n_r + NW'(1);
            state_nxt = S_RD_LO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.cluster        = out_r.cluster;
  assign out_item.sector_address = out_r.sector_address;
  assign out_item.chain_link     = out_r.chain_link;
  assign out_item.status         = out_r.status;
  assign out_item.last           = out_r.last;

  `FAT_ASSERT_IMP(a_run_cap, state_r == S_EVAL && n_r == NW'(MAX_RUN - 1), eval_res.last, "walk ran past its limit")
  `FAT_ASSERT_NXT(a_load_ack, in_fire && in_item.command == CMD_LOAD, state_r == S_SEND && res_r.last && res_r.status == ST_OK, "load not acknowledged")
  `FAT_ASSERT_IMP(a_eval_order, state_r == S_EVAL, $past(state_r) == S_RD_HI, "entry decoded before both bytes were read")
  `FAT_ASSERT_IMP(a_beyond_end, state_r == S_EVAL && beyond_r, eval_res.last && eval_res.chain_link == 12'd0, "entry beyond table did not end the walk")

endmodule

### verif/tb_top.sv
// Self-checking testbench of the FAT12 cluster chain walker: random table loads and chain walks.
module tb_top;
  import fat12_cw_pkg::*;

  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic        command;
    logic [12:0] table_offset;
    logic [7:0]  table_byte;
    logic [11:0] start_cluster;
  } fat_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DATA_START;
  logic [15:0] cfg_wdata = 16'd0;

  fat12_cw_in_if  in_ch ();
  fat12_cw_out_if out_ch ();

  fat12_cluster_chain_walker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Table and registers as the block should hold them.
  logic [7:0]  fat_bytes [TABLE_BYTES_DEF];
  logic [15:0] lba_reg = DATA_START_RESET;
  logic [7:0]  spc_reg = SPC_RESET;
  logic [13:0] tbu_reg = TABLE_BYTES_RESET;
  result_t     due_links [$];

  // Table contents as planned by the stimulus, ahead of what the block has taken.
  bit [7:0]    plan_bytes [TABLE_BYTES_DEF];
  bit          plan_known [TABLE_BYTES_DEF];
  fat_cmd_t    cmd_q [$];
  int          queued = 0;

  bit          in_took = 1'b0;
  bit          calm = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          faults = 0;
  longint      cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t link(input logic [11:0] cl, input logic [19:0] sec,
                                   input logic [11:0] nxt, input status_t st,
                                   input logic lst);
    result_t r;
    r.cluster        = cl;
    r.sector_address = sec;
    r.chain_link     = nxt;
    r.status         = st;
    r.last           = lst;
    return r;
  endfunction

  function automatic logic [19:0] sector_of_cluster(input logic [11:0] cl);
    longint s;
    s = longint'(lba_reg) + (longint'(cl) - 2) * longint'(spc_reg);
    return (s > longint'(SECTOR_MAX)) ? SECTOR_MAX : s[19:0];
  endfunction

  function automatic int unsigned table_limit();
    return (tbu_reg < TABLE_BYTES_DEF) ? int'(tbu_reg) : TABLE_BYTES_DEF;
  endfunction

  function automatic int unsigned entry_pos(input logic [11:0] cl);
    int unsigned pos;
    pos = cl;
    return pos * 3 / 2;
  endfunction

  function automatic logic [11:0] entry_of(input logic [11:0] cl, input logic [15:0] word);
    return cl[0] ? word[15:4] : word[11:0];
  endfunction

  task automatic trace_fat_chain(input fat_cmd_t c);
    logic [11:0] cl;
    logic [11:0] nxt;
    logic [19:0] sec;
    int unsigned pos;
    int unsigned lim;
    int          n;
    bit          done;
    if (c.command == CMD_LOAD) begin
      fat_bytes[c.table_offset] = c.table_byte;
      due_links.push_back(link(12'd0, 20'd0, 12'd0, ST_OK, 1'b1));
    end else if (c.start_cluster < FIRST_DATA_CLUSTER || c.start_cluster >= CHAIN_END) begin
      due_links.push_back(link(c.start_cluster, 20'd0, 12'd0, ST_BAD, 1'b1));
    end else begin
      lim  = table_limit();
      cl   = c.start_cluster;
      n    = 0;
      done = 1'b0;
      while (!done) begin
        pos = entry_pos(cl);
        sec = sector_of_cluster(cl);
        done = 1'b1;
        if (pos + 1 >= lim) begin
          due_links.push_back(link(cl, sec, 12'd0, ST_BEYOND, 1'b1));
        end else begin
          nxt = entry_of(cl, {fat_bytes[pos + 1], fat_bytes[pos]});
          if (nxt >= CHAIN_END) begin
            due_links.push_back(link(cl, sec, nxt, ST_OK, 1'b1));
          end else if (nxt < FIRST_DATA_CLUSTER) begin
            due_links.push_back(link(cl, sec, nxt, ST_BAD, 1'b1));
          end else if (n + 1 >= MAX_RUN_DEF) begin
            due_links.push_back(link(cl, sec, nxt, ST_CUT, 1'b1));
          end else begin
            due_links.push_back(link(cl, sec, nxt, ST_OK, 1'b0));
            n++;
            cl = nxt;
            done = 1'b0;
          end
        end
      end
    end
  endtask

  // A walk may only be issued if every table byte it reads has been loaded.
  function automatic bit walk_is_defined(input logic [11:0] start);
    logic [11:0] cl;
    logic [11:0] nxt;
    int unsigned pos;
    int unsigned lim;
    if (start < FIRST_DATA_CLUSTER || start >= CHAIN_END) return 1'b1;
    lim = table_limit();
    cl  = start;
    for (int n = 0; n < MAX_RUN_DEF; n++) begin
      pos = entry_pos(cl);
      if (pos + 1 >= lim) return 1'b1;
      if (!plan_known[pos] || !plan_known[pos + 1]) return 1'b0;
      nxt = entry_of(cl, {plan_bytes[pos + 1], plan_bytes[pos]});
      if (nxt >= CHAIN_END || nxt < FIRST_DATA_CLUSTER) return 1'b1;
      cl = nxt;
    end
    return 1'b1;
  endfunction

  task automatic queue_load(input logic [12:0] off, input logic [7:0] b);
    fat_cmd_t c;
    c.command       = CMD_LOAD;
    c.table_offset  = off;
    c.table_byte    = b;
    c.start_cluster = 12'($urandom_range(0, 4095));
    plan_bytes[off] = b;
    plan_known[off] = 1'b1;
    cmd_q.push_back(c);
    queued++;
  endtask

  task automatic queue_walk(input logic [11:0] start);
    fat_cmd_t c;
    if (walk_is_defined(start)) begin
      c.command       = CMD_WALK;
      c.table_offset  = 13'($urandom_range(0, 8191));
      c.table_byte    = 8'($urandom_range(0, 255));
      c.start_cluster = start;
      cmd_q.push_back(c);
      queued++;
    end
  endtask

  task automatic set_entry(input logic [11:0] cl, input logic [11:0] v);
    int unsigned pos;
    logic [15:0] word;
    pos  = entry_pos(cl);
    word = {plan_bytes[pos + 1], plan_bytes[pos]};
    if (cl[0]) word = {v, word[3:0]};
    else word = {word[15:12], v};
    queue_load(pos[12:0], word[7:0]);
    queue_load(pos[12:0] + 13'd1, word[15:8]);
  endtask

  task automatic build_chain(input int len, input int lo, input int hi);
    logic [11:0] members [$];
    bit          taken [int];
    logic [11:0] pick;
    logic [11:0] tail;
    int          tries;
    int          sel;
    tries = 0;
    while (members.size() < len && tries < 100) begin
      pick = 12'($urandom_range(lo, hi));
      tries++;
      if (!taken.exists(pick)) begin
        taken[pick] = 1'b1;
        members.push_back(pick);
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) tail = 12'($urandom_range(CHAIN_END, 12'hFFF));
    else if (sel == 5) tail = 12'($urandom_range(0, 1));
    else if (sel < 8) tail = members[$urandom_range(0, members.size() - 1)];
    else tail = 12'($urandom_range(FIRST_DATA_CLUSTER, CHAIN_END - 1));
    foreach (members[i]) begin
      set_entry(members[i], (i + 1 < members.size()) ? members[i + 1] : tail);
    end
    queue_walk(members[0]);
    if ($urandom_range(0, 3) == 0) queue_walk(members[$urandom_range(0, members.size() - 1)]);
  endtask

  task automatic fill_random(input int budget);
    int goal;
    int r;
    int len;
    int k;
    goal = queued + budget;
    while (queued < goal) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        k = $urandom_range(0, 9);
        if (k < 6) build_chain(len, 2, 120);
        else if (k < 8) build_chain(len, 2, CHAIN_END - 1);
        else build_chain(len, 3800, CHAIN_END - 1);
      end else if (r < 17) begin
        queue_load(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
      end else if (r == 17) begin
        queue_walk(($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 1))
                                               : 12'($urandom_range(CHAIN_END, 12'hFFF)));
      end else begin
        queue_walk(12'($urandom_range(0, 4095)));
      end
    end
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || due_links.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DATA_START:  lba_reg = val;
      CFG_SPC:         spc_reg = val[7:0];
      CFG_TABLE_BYTES: tbu_reg = val[13:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] lba, input logic [7:0] spc,
                           input logic [13:0] tbu, input int budget);
    settle();
    write_reg(CFG_DATA_START, lba);
    write_reg(CFG_SPC, {8'd0, spc});
    write_reg(CFG_TABLE_BYTES, {2'd0, tbu});
    fill_random(budget);
  endtask

  task automatic check_link();
    result_t got;
    result_t want;
    got = link(out_ch.cluster, out_ch.sector_address, out_ch.chain_link,
               status_t'(out_ch.status), out_ch.last);
    if (due_links.size() == 0) begin
      faults++;
      if (faults <= 10) begin
        $display("unexpected item: cluster %0d sector %0d next %0d status %0d last %0d",
                 got.cluster, got.sector_address, got.chain_link, got.status, got.last);
      end
    end else begin
      want = due_links.pop_front();
      if (got.cluster !== want.cluster || got.sector_address !== want.sector_address ||
          got.chain_link !== want.chain_link || got.status !== want.status ||
          got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch: cluster %0d/%0d sector %0d/%0d next %0d/%0d status %0d/%0d last %0d/%0d (expected/actual)",
                   want.cluster, got.cluster, want.sector_address, got.sector_address,
                   want.chain_link, got.chain_link, want.status, got.status,
                   want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        trace_fat_chain(cmd_q[0]);
        void'(cmd_q.pop_front());
        in_took = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) check_link();
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_took) begin
        if (in_took && !calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 17);
        in_took = 1'b0;
        if (in_gap > 0 && !calm) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          in_ch.valid         <= 1'b1;
          in_ch.command       <= cmd_q[0].command;
          in_ch.table_offset  <= cmd_q[0].table_offset;
          in_ch.table_byte    <= cmd_q[0].table_byte;
          in_ch.start_cluster <= cmd_q[0].start_cluster;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_stall == 0 && !calm && $urandom_range(0, 11) == 0) begin
        out_stall = $urandom_range(1, 17);
      end
      if (out_stall > 0 && !calm) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_LOAD;
    in_ch.table_offset  = 13'd0;
    in_ch.table_byte    = 8'd0;
    in_ch.start_cluster = 12'd0;
    out_ch.ready        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values.
    queue_walk(12'd0);
    queue_walk(12'd1);
    queue_walk(CHAIN_END);
    queue_walk(12'hFFF);
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'hFFF);
    queue_walk(12'd2);
    set_entry(12'd4, 12'd0);
    queue_walk(12'd4);
    set_entry(12'd5, 12'd5);
    queue_walk(12'd5);
    set_entry(CHAIN_END - 12'd1, CHAIN_END);
    queue_walk(CHAIN_END - 12'd1);
    queue_load(13'h1FFF, 8'hFF);
    queue_load(13'h0000, 8'h00);
    set_entry(12'd6, 12'd1);
    queue_walk(12'd6);

    run_phase(16'hFFFF, 8'd128, 14'd8192, 50);
    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 128)),
              14'($urandom_range(100, 400)), 50);
    run_phase(16'd0, 8'd1, 14'd0, 15);
    run_phase(16'hF000, 8'd255, 14'h3FFF, 50);
    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 128)),
              14'($urandom_range(4000, 8192)), 45);
    settle();
    calm = 1'b1;
    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 128)), 14'd8192, 60);

    settle();
    repeat (200) @(posedge clk);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/fat12_cw_pkg.sv
rtl/fat12_cw_if.sv
rtl/fat12_cluster_chain_walker_core.sv
verif/tb_top.sv
